>>> design/i2cmw_pkg.sv
// i2cmw_pkg: types and constants shared by the write-only I2C master
// used by i2cmw_fifo, i2c_master_write and i2cmw_checker; no dependencies
`default_nettype none

package i2cmw_pkg;

  // channel payload widths
  localparam int unsigned IN_DATA_W  = 32;
  localparam int unsigned IN_USER_W  = 2;
  localparam int unsigned OUT_DATA_W = 8;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 16;

  // default depth of the byte buffer
  localparam int unsigned BUFFER_DEPTH_DEF = 16;

  // register reset values
  localparam logic [15:0] UNIT_TICKS_RST = 16'd100;
  localparam logic [7:0]  ACK_LIMIT_RST  = 8'd100;

  // bits per byte on the wire
  localparam logic [3:0] BITS_PER_BYTE = 4'd8;

  // command codes carried on in_tuser
  localparam logic [IN_USER_W-1:0] CMD_TICK  = 2'd0;
  localparam logic [IN_USER_W-1:0] CMD_START = 2'd1;
  localparam logic [IN_USER_W-1:0] CMD_PUSH  = 2'd2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_UNIT_TICKS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ACK_LIMIT  = 2'd1;

  // completion codes
  localparam logic [1:0] ST_NONE     = 2'd0;
  localparam logic [1:0] ST_DONE     = 2'd1;
  localparam logic [1:0] ST_ADDR_NAK = 2'd2;
  localparam logic [1:0] ST_DATA_NAK = 2'd3;

  // bus sequencer phases
  typedef enum logic [3:0] {
    PH_IDLE,
    PH_START_HIGH,
    PH_START_LOW,
    PH_BIT_LOW,
    PH_BIT_HIGH,
    PH_ACK_RELEASE,
    PH_ACK_HIGH,
    PH_ACK_POLL,
    PH_BYTE_WAIT,
    PH_STOP_LOW,
    PH_STOP_HIGH,
    PH_STOP_DONE
  } phase_t;

  // byte buffer status towards the sequencer
  typedef struct packed {
    logic empty;
    logic full;
  } fifo_stat_t;

endpackage

`default_nettype wire

>>> design/i2cmw_fifo.sv
// i2cmw_fifo: byte buffer with a registered head byte for the I2C master
// depends on i2cmw_pkg
`default_nettype none

module i2cmw_fifo #(
  parameter int unsigned DEPTH = i2cmw_pkg::BUFFER_DEPTH_DEF
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   push,
  input  wire logic [7:0]             push_data,
  input  wire logic                   pop,
  output logic [7:0]                  head,
  output i2cmw_pkg::fifo_stat_t       stat,
  output logic                        full_nxt
);
  import i2cmw_pkg::*;

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  logic [7:0]    mem [DEPTH];
  logic [AW-1:0] wr_idx_r, wr_idx_nxt;
  logic [AW-1:0] rd_idx_r, rd_idx_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic [7:0]    head_r;

  // pointer and fill count updates
  always_comb begin
    wr_idx_nxt = wr_idx_r;
    rd_idx_nxt = rd_idx_r;
    count_nxt  = count_r;
    if (push) begin
      wr_idx_nxt = (wr_idx_r == LAST_IDX) ? '0 : wr_idx_r + 1'b1;
    end
    if (pop) begin
      rd_idx_nxt = (rd_idx_r == LAST_IDX) ? '0 : rd_idx_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_idx_r <= '0;
      rd_idx_r <= '0;
      count_r  <= '0;
    end else begin
      wr_idx_r <= wr_idx_nxt;
      rd_idx_r <= rd_idx_nxt;
      count_r  <= count_nxt;
    end
  end

  // storage write
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_idx_r] <= push_data;
    end
  end

  // registered head read, with the byte being written passed straight through
  always_ff @(posedge clk) begin
    if (push && (wr_idx_r == rd_idx_nxt)) begin
      head_r <= push_data;
    end else begin
      head_r <= mem[rd_idx_nxt];
    end
  end

  assign head       = head_r;
  assign stat.empty = (count_r == '0);
  assign stat.full  = (count_r == FULL_CNT);

  // full flag as it stands after this cycle's push or pop
  assign full_nxt   = (count_nxt == FULL_CNT);

endmodule

`default_nettype wire

>>> design/i2c_master_write.sv
// i2c_master_write: tick-driven I2C master for write transactions
// depends on i2cmw_pkg and i2cmw_fifo
//
// Usage
//   in_* channel: one item per transfer. in_tuser carries the command
//   (tick with SDA sample, start transaction, push data byte); in_tdata
//   carries slave address, byte count, data byte and the sampled SDA level.
//   out_* channel: exactly one result per accepted item, in order: SCL level,
//   SDA release, busy flag, completion status and buffer-full flag.
//   cfg_* channel: register writes (unit ticks, ACK poll limit), always ready;
//   write them only while no item is in flight.
// Timing
//   Each item is handled in one pass between the input and the result
//   register: its result appears in the cycle after acceptance, and one
//   item can be accepted every cycle while out_tready is high. The output
//   register is the only buffer: while a result waits and out_tready is low, in_tready is low too.
// Reset
//   Synchronous, active low: the sequencer goes idle with both lines low,
//   the buffer empties and the registers take their default values.
`default_nettype none

module i2c_master_write #(
  parameter int unsigned BUFFER_DEPTH = i2cmw_pkg::BUFFER_DEPTH_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  // input channel
  input  wire logic                              in_tvalid,
  output logic                                   in_tready,
  // [6:0] target_addr, [22:7] byte_count, [30:23] data_byte, [31] sda_in
  input  wire logic [i2cmw_pkg::IN_DATA_W-1:0]   in_tdata,
  // [1:0] cmd
  input  wire logic [i2cmw_pkg::IN_USER_W-1:0]   in_tuser,
  // result channel
  output logic                                   out_tvalid,
  input  wire logic                              out_tready,
  // [0] scl, [1] sda_release, [2] busy_res, [4:3] status, [5] buffer_full
  output logic [i2cmw_pkg::OUT_DATA_W-1:0]       out_tdata,
  // configuration write channel
  input  wire logic                              cfg_valid,
  output logic                                   cfg_ready,
  input  wire logic [i2cmw_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [i2cmw_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import i2cmw_pkg::*;

  // input field views
  logic [IN_USER_W-1:0] cmd;
  logic [6:0]           target_addr;
  logic [15:0]          byte_count;
  logic [7:0]           data_byte;
  logic                 sda_in;

  assign cmd           = in_tuser;
  assign target_addr   = in_tdata[6:0];
  assign byte_count    = in_tdata[22:7];
  assign data_byte     = in_tdata[30:23];
  assign sda_in        = in_tdata[31];

  // handshake
  logic in_acc;
  logic out_valid_r;
  logic [OUT_DATA_W-1:0] out_data_r;

  assign in_tready = !out_valid_r || out_tready;
  assign in_acc    = in_tvalid && in_tready;

  // configuration registers
  logic [15:0] unit_ticks_r;
  logic [7:0]  ack_limit_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      unit_ticks_r <= UNIT_TICKS_RST;
      ack_limit_r  <= ACK_LIMIT_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_UNIT_TICKS: unit_ticks_r <= cfg_data;
        REG_ACK_LIMIT:  ack_limit_r  <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // sequencer state
  phase_t      phase_r, phase_nxt;
  logic [15:0] delay_r, delay_nxt;
  logic        unit_r, unit_nxt;
  logic [3:0]  bit_idx_r, bit_idx_nxt;
  logic [7:0]  shift_r, shift_nxt;
  logic [15:0] bytes_left_r, bytes_left_nxt;
  logic [7:0]  poll_r, poll_nxt;
  logic        scl_r, scl_nxt;
  logic        sda_r, sda_nxt;
  logic        data_phase_r, data_phase_nxt;
  logic [1:0]  end_st_r, end_st_nxt;
  logic [1:0]  status;
  logic        pop;

  // byte buffer
  logic       push;
  logic [7:0] head;
  fifo_stat_t fstat;
  logic       full_after;

  assign push = in_acc && (cmd == CMD_PUSH) && !fstat.full;

  i2cmw_fifo #(
    .DEPTH(BUFFER_DEPTH)
  ) u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_data(data_byte),
    .pop      (pop),
    .head     (head),
    .stat     (fstat),
    .full_nxt (full_after)
  );

  // segment timing: unit length, zero acting as one
  logic [15:0] unit_lim;
  logic [16:0] delay_inc;
  logic        unit_end;
  logic        two_units;
  logic        seg_end;
  logic [8:0]  poll_inc;
  logic [7:0]  poll_lim;
  logic [3:0]  bit_inc;

  assign unit_lim  = (unit_ticks_r == '0) ? 16'd1 : unit_ticks_r;
  assign delay_inc = {1'b0, delay_r} + 17'd1;
  assign unit_end  = (delay_inc >= {1'b0, unit_lim});
  assign two_units = (phase_r == PH_START_HIGH) || (phase_r == PH_START_LOW) ||
                     (phase_r == PH_STOP_LOW)   || (phase_r == PH_STOP_DONE);
  assign seg_end   = unit_end && (!two_units || unit_r);
  assign poll_lim  = (ack_limit_r == '0) ? 8'd1 : ack_limit_r;
  assign poll_inc  = {1'b0, poll_r} + 9'd1;
  assign bit_inc   = bit_idx_r + 4'd1;

  // next state
  always_comb begin
    phase_nxt      = phase_r;
    delay_nxt      = delay_r;
    unit_nxt       = unit_r;
    bit_idx_nxt    = bit_idx_r;
    shift_nxt      = shift_r;
    bytes_left_nxt = bytes_left_r;
    poll_nxt       = poll_r;
    scl_nxt        = scl_r;
    sda_nxt        = sda_r;
    data_phase_nxt = data_phase_r;
    end_st_nxt     = end_st_r;
    pop            = 1'b0;

    if (in_acc && (cmd == CMD_START) && (phase_r == PH_IDLE)) begin
      // latch address with write bit clear and begin the start condition
      shift_nxt      = {target_addr, 1'b0};
      bytes_left_nxt = byte_count;
      data_phase_nxt = 1'b0;
      end_st_nxt     = ST_NONE;
      poll_nxt       = '0;
      bit_idx_nxt    = '0;
      phase_nxt      = PH_START_HIGH;
      scl_nxt        = 1'b1;
      sda_nxt        = 1'b1;
      delay_nxt      = '0;
      unit_nxt       = 1'b0;
    end else if (in_acc && (cmd == CMD_TICK)) begin
      // advance the timed segment of the timed phases
      if ((phase_r != PH_IDLE) && (phase_r != PH_ACK_POLL) &&
          (phase_r != PH_BYTE_WAIT)) begin
        delay_nxt = unit_end ? '0 : delay_inc[15:0];
        if (unit_end) begin
          unit_nxt = !seg_end;
        end
      end
      unique case (phase_r)
        PH_START_HIGH: begin
          if (seg_end) begin
            phase_nxt = PH_START_LOW;
            scl_nxt   = 1'b1;
            sda_nxt   = 1'b0;
          end
        end
        PH_START_LOW: begin
          if (seg_end) begin
            bit_idx_nxt = '0;
            phase_nxt   = PH_BIT_LOW;
            scl_nxt     = 1'b0;
            sda_nxt     = shift_r[7];
          end
        end
        PH_BIT_LOW: begin
          if (seg_end) begin
            phase_nxt = PH_BIT_HIGH;
            scl_nxt   = 1'b1;
          end
        end
        PH_BIT_HIGH: begin
          if (seg_end) begin
            shift_nxt   = {shift_r[6:0], 1'b0};
            bit_idx_nxt = bit_inc;
            if (bit_inc < BITS_PER_BYTE) begin
              phase_nxt = PH_BIT_LOW;
              scl_nxt   = 1'b0;
              sda_nxt   = shift_r[6];
            end else begin
              phase_nxt = PH_ACK_RELEASE;
              scl_nxt   = 1'b0;
              sda_nxt   = 1'b1;
            end
          end
        end
        PH_ACK_RELEASE: begin
          if (seg_end) begin
            phase_nxt = PH_ACK_HIGH;
            scl_nxt   = 1'b1;
            sda_nxt   = 1'b1;
          end
        end
        PH_ACK_HIGH: begin
          if (seg_end) begin
            phase_nxt = PH_ACK_POLL;
            poll_nxt  = '0;
          end
        end
        PH_ACK_POLL: begin
          if (!sda_in) begin
            // acknowledged: pull SCL low; next byte (or wait for one), or stop if none are left
            scl_nxt        = 1'b0;
            data_phase_nxt = 1'b1;
            if (bytes_left_r == '0) begin
              end_st_nxt = ST_DONE;
              phase_nxt  = PH_STOP_LOW;
              sda_nxt    = 1'b0;
              delay_nxt  = '0;
              unit_nxt   = 1'b0;
            end else if (fstat.empty) begin
              phase_nxt = PH_BYTE_WAIT;
            end else begin
              pop            = 1'b1;
              shift_nxt      = head;
              bytes_left_nxt = bytes_left_r - 16'd1;
              bit_idx_nxt    = '0;
              phase_nxt      = PH_BIT_LOW;
              sda_nxt        = head[7];
              delay_nxt      = '0;
              unit_nxt       = 1'b0;
            end
          end else begin
            poll_nxt = poll_inc[7:0];
            if (poll_inc >= {1'b0, poll_lim}) begin
              end_st_nxt = data_phase_r ? ST_DATA_NAK : ST_ADDR_NAK;
              phase_nxt  = PH_STOP_LOW;
              scl_nxt    = 1'b0;
              sda_nxt    = 1'b0;
              delay_nxt  = '0;
              unit_nxt   = 1'b0;
            end
          end
        end
        PH_BYTE_WAIT: begin
          if (!fstat.empty) begin
            pop            = 1'b1;
            shift_nxt      = head;
            bytes_left_nxt = bytes_left_r - 16'd1;
            bit_idx_nxt    = '0;
            phase_nxt      = PH_BIT_LOW;
            scl_nxt        = 1'b0;
            sda_nxt        = head[7];
            delay_nxt      = '0;
            unit_nxt       = 1'b0;
          end
        end
        PH_STOP_LOW: begin
          if (seg_end) begin
            phase_nxt = PH_STOP_HIGH;
            scl_nxt   = 1'b1;
            sda_nxt   = 1'b0;
          end
        end
        PH_STOP_HIGH: begin
          if (seg_end) begin
            phase_nxt = PH_STOP_DONE;
            scl_nxt   = 1'b1;
            sda_nxt   = 1'b1;
          end
        end
        PH_STOP_DONE: begin
          if (seg_end) begin
            phase_nxt = PH_IDLE;
          end
        end
        default: ;
      endcase
    end
  end

  // result outputs: status only on the tick that finishes the stop
  always_comb begin
    status = ST_NONE;
    if (in_acc && (cmd == CMD_TICK) && (phase_r == PH_STOP_DONE) && seg_end) begin
      status = end_st_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_IDLE;
      delay_r      <= '0;
      unit_r       <= 1'b0;
      bit_idx_r    <= '0;
      shift_r      <= '0;
      bytes_left_r <= '0;
      poll_r       <= '0;
      scl_r        <= 1'b0;
      sda_r        <= 1'b0;
      data_phase_r <= 1'b0;
      end_st_r     <= ST_NONE;
    end else begin
      phase_r      <= phase_nxt;
      delay_r      <= delay_nxt;
      unit_r       <= unit_nxt;
      bit_idx_r    <= bit_idx_nxt;
      shift_r      <= shift_nxt;
      bytes_left_r <= bytes_left_nxt;
      poll_r       <= poll_nxt;
      scl_r        <= scl_nxt;
      sda_r        <= sda_nxt;
      data_phase_r <= data_phase_nxt;
      end_st_r     <= end_st_nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_acc) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      out_data_r <= {2'b00, full_after, status, (phase_nxt != PH_IDLE), sda_nxt, scl_nxt};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

`default_nettype wire

>>> design/i2cmw_checker.sv
// i2cmw_checker: port-level checks for i2c_master_write, bound to the top level
// depends on i2cmw_pkg
`default_nettype none

module i2cmw_checker (
  input wire logic                              clk,
  input wire logic                              rst_n,
  input wire logic                              in_tvalid,
  input wire logic                              in_tready,
  input wire logic                              out_tvalid,
  input wire logic                              out_tready,
  input wire logic [i2cmw_pkg::OUT_DATA_W-1:0]  out_tdata
);
  import i2cmw_pkg::*;

  // a completion status is reported only once the bus has gone idle
  a_status_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && (out_tdata[4:3] != ST_NONE)) |-> !out_tdata[2])
    else $error("status reported while busy");

  // a finished stop leaves both lines released high
  a_stop_lines: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && (out_tdata[4:3] != ST_NONE)) |-> (out_tdata[0] && out_tdata[1]))
    else $error("stop ended with a line low");

  // an empty result slot never blocks the input
  a_ready_free: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready)
    else $error("input stalled with an empty result slot");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=> (out_tvalid && $stable(out_tdata)))
    else $error("stalled result changed");

  // an accepted item always yields a result in the next cycle
  a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> out_tvalid)
    else $error("accepted item produced no result");

endmodule

bind i2c_master_write i2cmw_checker u_i2cmw_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_tvalid (in_tvalid),
  .in_tready (in_tready),
  .out_tvalid(out_tvalid),
  .out_tready(out_tready),
  .out_tdata (out_tdata)
);

`default_nettype wire
